// ===== hw/rtl/bstc_pkg.sv =====
// shared types and constants for the barometric trim compensation pipeline
// no dependencies

package bstc_pkg;

  localparam int RawW       = 20;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 64;
  localparam int DivSteps   = 64;
  localparam int FineOffset = 128000;
  localparam int DivScale   = 3125;
  localparam int PressBase  = 1048576;
  localparam int TempRound  = 128;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TEMP_TRIM  = 2'd0,
    CFG_PRESS_LOW  = 2'd1,
    CFG_PRESS_MID  = 2'd2,
    CFG_PRESS_HIGH = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [RawW-1:0] raw_temperature;
    logic [RawW-1:0] raw_pressure;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] temperature_centi;
    logic signed [31:0] fine_temperature;
    logic [31:0]        pressure_q24_8;
    logic               pressure_valid;
  } out_item_t;

  typedef struct packed {
    logic [47:0] temp_trim;
    logic [63:0] press_trim_low;
    logic [63:0] press_trim_mid;
    logic [15:0] press_trim_high;
  } trim_t;

  // per-request sideband carried past the divider
  typedef struct packed {
    logic signed [31:0] tcent;
    logic signed [31:0] fine;
    logic               zero;
    logic               neg;
  } side_t;

endpackage

// ===== hw/rtl/bstc_front.sv =====
// front pipeline: temperature compensation and divider operand preparation
// depends on bstc_pkg

module bstc_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             up_valid,
  output logic             up_ready,
  input  bstc_pkg::in_item_t up_data,
  input  bstc_pkg::trim_t  trim,
  output logic             dn_valid,
  input  logic             dn_ready,
  output logic [63:0]      dn_num,
  output logic [30:0]      dn_den,
  output bstc_pkg::side_t  dn_side
);
  import bstc_pkg::*;

  localparam int NStg = 12;

  logic [NStg-1:0] vld_r;
  logic [NStg-1:0] vin;
  logic [NStg:0]   en;

  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6;

  logic signed [18:0] d1_r, d1_nxt;
  logic signed [17:0] d2_r, d2_nxt;
  logic [20:0]        p0_r [0:8];
  logic [20:0]        p0_nxt;
  logic signed [34:0] v1p_r, v1p_nxt;
  logic signed [35:0] dsq_r, dsq_nxt;
  logic signed [23:0] v1_r, v1_nxt;
  logic signed [23:0] dsh;
  logic signed [39:0] v2p_r, v2p_nxt;
  logic signed [25:0] v2s;
  logic signed [31:0] fn_r [3:10];
  logic signed [31:0] fine_nxt;
  logic signed [35:0] trnd;
  logic signed [27:0] tsh;
  logic signed [31:0] tc_r [4:10];
  logic signed [32:0] a_r, a_nxt;
  logic signed [65:0] aa_full;
  logic signed [54:0] aa_r, aa_nxt;
  logic signed [48:0] ap5_r, ap5_nxt, ap2_r, ap2_nxt, ap5d_r, ap2d_r;
  logic signed [70:0] bm_full, a3m_full;
  logic [63:0]        bm_r, bm_nxt;
  logic signed [63:0] a3m_r, a3m_nxt;
  logic [63:0]        b_r, b_nxt, b8_r;
  logic signed [63:0] a2_r, a2_nxt, a2s;
  logic signed [80:0] a2p_full;
  logic [63:0]        a2p_r, a2p_nxt;
  logic signed [30:0] den_r, den_nxt, den10_r;
  logic [63:0]        numpre_r, numpre_nxt;
  logic [75:0]        nprod;
  logic [63:0]        num_r, num_nxt;
  logic [63:0]        unum_r, unum_nxt;
  logic [30:0]        uden_r, uden_nxt;
  side_t              side_r, side_nxt;

  assign t1 = trim.temp_trim[15:0];
  assign t2 = trim.temp_trim[31:16];
  assign t3 = trim.temp_trim[47:32];
  assign p1 = trim.press_trim_low[15:0];
  assign p2 = trim.press_trim_low[31:16];
  assign p3 = trim.press_trim_low[47:32];
  assign p4 = trim.press_trim_low[63:48];
  assign p5 = trim.press_trim_mid[15:0];
  assign p6 = trim.press_trim_mid[31:16];

  assign en[NStg] = dn_ready;
  for (genvar k = 0; k < NStg; k++) begin : g_en
    assign en[k] = !vld_r[k] | en[k+1];
  end
  assign vin      = {vld_r[NStg-2:0], up_valid};
  assign up_ready = en[0];

  always_comb begin
    d1_nxt   = $signed({2'b00, up_data.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
    d2_nxt   = $signed({2'b00, up_data.raw_temperature[19:4]}) - $signed({2'b00, t1});
    p0_nxt   = 21'(PressBase) - {1'b0, up_data.raw_pressure};
    v1p_nxt  = d1_r * t2;
    dsq_nxt  = d2_r * d2_r;
    v1_nxt   = v1p_r[34:11];
    dsh      = dsq_r[35:12];
    v2p_nxt  = dsh * t3;
    v2s      = v2p_r[39:14];
    fine_nxt = 32'(v1_r) + 32'(v2s);
    trnd     = fn_r[3] * 36'sd5 + 36'(TempRound);
    tsh      = trnd[35:8];
    a_nxt    = fn_r[3] - 33'(FineOffset);
    aa_full  = a_r * a_r;
    aa_nxt   = aa_full[54:0];
    ap5_nxt  = a_r * p5;
    ap2_nxt  = a_r * p2;
    bm_full  = aa_r * p6;
    a3m_full = aa_r * p3;
    bm_nxt   = bm_full[63:0];
    a3m_nxt  = a3m_full[63:0];
    b_nxt    = bm_r + (64'(ap5d_r) << 17) + (64'(p4) << 35);
    a2_nxt   = (a3m_r >>> 8) + (64'(ap2d_r) << 12);
    a2s      = a2_r + 64'h0000_8000_0000_0000;
    a2p_full = a2s * $signed({1'b0, p1});
    a2p_nxt  = a2p_full[63:0];
    den_nxt  = a2p_r[63:33];
    numpre_nxt = ({43'd0, p0_r[8]} << 31) - b8_r;
    nprod    = numpre_r * 12'(DivScale);
    num_nxt  = nprod[63:0];
    unum_nxt = num_r[63] ? (~num_r + 64'd1) : num_r;
    uden_nxt = den10_r[30] ? (~den10_r + 31'd1) : den10_r;
    side_nxt.tcent = tc_r[10];
    side_nxt.fine  = fn_r[10];
    side_nxt.zero  = (den10_r == '0);
    side_nxt.neg   = num_r[63] ^ den10_r[30];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NStg; k++) begin
        if (en[k]) vld_r[k] <= vin[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d1_r     <= d1_nxt;
      d2_r     <= d2_nxt;
      p0_r[0]  <= p0_nxt;
    end
    for (int k = 1; k <= 8; k++) begin
      if (en[k]) p0_r[k] <= p0_r[k-1];
    end
    if (en[1]) begin
      v1p_r <= v1p_nxt;
      dsq_r <= dsq_nxt;
    end
    if (en[2]) begin
      v1_r  <= v1_nxt;
      v2p_r <= v2p_nxt;
    end
    if (en[3]) fn_r[3] <= fine_nxt;
    for (int k = 4; k <= 10; k++) begin
      if (en[k]) fn_r[k] <= fn_r[k-1];
    end
    if (en[4]) begin
      tc_r[4] <= 32'(tsh);
      a_r     <= a_nxt;
    end
    for (int k = 5; k <= 10; k++) begin
      if (en[k]) tc_r[k] <= tc_r[k-1];
    end
    if (en[5]) begin
      aa_r  <= aa_nxt;
      ap5_r <= ap5_nxt;
      ap2_r <= ap2_nxt;
    end
    if (en[6]) begin
      bm_r   <= bm_nxt;
      a3m_r  <= a3m_nxt;
      ap5d_r <= ap5_r;
      ap2d_r <= ap2_r;
    end
    if (en[7]) begin
      b_r  <= b_nxt;
      a2_r <= a2_nxt;
    end
    if (en[8]) begin
      a2p_r <= a2p_nxt;
      b8_r  <= b_r;
    end
    if (en[9]) begin
      den_r    <= den_nxt;
      numpre_r <= numpre_nxt;
    end
    if (en[10]) begin
      num_r   <= num_nxt;
      den10_r <= den_r;
    end
    if (en[11]) begin
      unum_r <= unum_nxt;
      uden_r <= uden_nxt;
      side_r <= side_nxt;
    end
  end

  assign dn_valid = vld_r[NStg-1];
  assign dn_num   = unum_r;
  assign dn_den   = uden_r;
  assign dn_side  = side_r;

endmodule

// ===== hw/rtl/bstc_div.sv =====
// pipelined restoring divider, one quotient bit per stage, unsigned magnitudes
// depends on bstc_pkg

module bstc_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  logic [63:0]     up_num,
  input  logic [30:0]     up_den,
  input  bstc_pkg::side_t up_side,
  output logic            dn_valid,
  input  logic            dn_ready,
  output logic [63:0]     dn_quot,
  output bstc_pkg::side_t dn_side
);
  import bstc_pkg::*;

  logic [DivSteps-1:0] vld_r;
  logic [DivSteps-1:0] vin;
  logic [DivSteps:0]   en;

  logic [30:0] rem_r [DivSteps];
  logic [63:0] nq_r  [DivSteps];
  logic [30:0] dv_r  [DivSteps];
  side_t       sd_r  [DivSteps];

  assign en[DivSteps] = dn_ready;
  assign vin          = {vld_r[DivSteps-2:0], up_valid};
  assign up_ready     = en[0];

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic [30:0] rem_in;
    logic [63:0] nq_in;
    logic [30:0] dv_in;
    side_t       sd_in;
    logic [31:0] trial;
    logic [32:0] diff;
    logic        ge;

    assign en[k] = !vld_r[k] | en[k+1];

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign nq_in  = up_num;
      assign dv_in  = up_den;
      assign sd_in  = up_side;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign nq_in  = nq_r[k-1];
      assign dv_in  = dv_r[k-1];
      assign sd_in  = sd_r[k-1];
    end

    assign trial = {rem_in, nq_in[63]};
    assign diff  = {1'b0, trial} - {2'b00, dv_in};
    assign ge    = !diff[32];

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k] <= ge ? diff[30:0] : trial[30:0];
        nq_r[k]  <= {nq_in[62:0], ge};
        dv_r[k]  <= dv_in;
        sd_r[k]  <= sd_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < DivSteps; k++) begin
        if (en[k]) vld_r[k] <= vin[k];
      end
    end
  end

  assign dn_valid = vld_r[DivSteps-1];
  assign dn_quot  = nq_r[DivSteps-1];
  assign dn_side  = sd_r[DivSteps-1];

endmodule

// ===== hw/rtl/bstc_post.sv =====
// back pipeline: quotient sign, second-order pressure terms, output register
// depends on bstc_pkg

module bstc_post (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  logic [63:0]        up_quot,
  input  bstc_pkg::side_t    up_side,
  input  bstc_pkg::trim_t    trim,
  output logic               dn_valid,
  input  logic               dn_ready,
  output bstc_pkg::out_item_t dn_data
);
  import bstc_pkg::*;

  localparam int NStg = 6;

  logic [NStg-1:0] vld_r;
  logic [NStg-1:0] vin;
  logic [NStg:0]   en;

  logic signed [15:0] p7, p8, p9;

  side_t              sd_r [0:4];
  logic signed [63:0] p_r, p_nxt;
  logic signed [63:0] pp_r [1:3];
  logic signed [63:0] ps;
  logic [63:0]        ll_r, ll_nxt, hl_full;
  logic [31:0]        hl_r, hl_nxt;
  logic [63:0]        sq_r, sq_nxt;
  logic signed [79:0] pd_full, m_full;
  logic signed [63:0] pd_r, pd_nxt, pd3_r, m_r, m_nxt;
  logic signed [63:0] x_r, x_nxt;
  out_item_t          out_r, out_nxt;

  assign p7 = trim.press_trim_mid[47:32];
  assign p8 = trim.press_trim_mid[63:48];
  assign p9 = trim.press_trim_high;

  assign en[NStg] = dn_ready;
  for (genvar k = 0; k < NStg; k++) begin : g_en
    assign en[k] = !vld_r[k] | en[k+1];
  end
  assign vin      = {vld_r[NStg-2:0], up_valid};
  assign up_ready = en[0];

  always_comb begin
    p_nxt   = up_side.neg ? (~up_quot + 64'd1) : up_quot;
    ps      = p_r >>> 13;
    ll_nxt  = ps[31:0] * ps[31:0];
    hl_full = ps[63:32] * ps[31:0];
    hl_nxt  = hl_full[31:0];
    sq_nxt  = ll_r + {hl_r[30:0], 33'd0};
    pd_full = pp_r[1] * p8;
    pd_nxt  = pd_full[63:0];
    m_full  = $signed(sq_r) * p9;
    m_nxt   = m_full[63:0];
    x_nxt   = pp_r[3] + (m_r >>> 25) + (pd3_r >>> 19);
    out_nxt.temperature_centi = sd_r[4].tcent;
    out_nxt.fine_temperature  = sd_r[4].fine;
    out_nxt.pressure_q24_8    = sd_r[4].zero ? 32'd0 : (x_r[39:8] + (32'(p7) << 4));
    out_nxt.pressure_valid    = !sd_r[4].zero;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NStg; k++) begin
        if (en[k]) vld_r[k] <= vin[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      p_r     <= p_nxt;
      sd_r[0] <= up_side;
    end
    for (int k = 1; k <= 4; k++) begin
      if (en[k]) sd_r[k] <= sd_r[k-1];
    end
    if (en[1]) begin
      ll_r    <= ll_nxt;
      hl_r    <= hl_nxt;
      pp_r[1] <= p_r;
    end
    if (en[2]) begin
      sq_r    <= sq_nxt;
      pd_r    <= pd_nxt;
      pp_r[2] <= pp_r[1];
    end
    if (en[3]) begin
      m_r     <= m_nxt;
      pd3_r   <= pd_r;
      pp_r[3] <= pp_r[2];
    end
    if (en[4]) x_r <= x_nxt;
    if (en[5]) out_r <= out_nxt;
  end

  assign dn_valid = vld_r[NStg-1];
  assign dn_data  = out_r;

endmodule

// ===== hw/rtl/baro_sensor_trim_compensation_unit.sv =====
// top level: trim registers, front pipeline, divider and back pipeline
// depends on bstc_pkg, bstc_front, bstc_div, bstc_post
// throughput: one request per cycle while out_ready holds no stall; the 64-stage divider sets the depth
// stalls back-pressure stage by stage, empty stages fill while the output waits
// reset clears all stage valid bits and sets every trim word to zero

module baro_sensor_trim_compensation_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  bstc_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output bstc_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [bstc_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [bstc_pkg::CfgDataW-1:0]     cfg_wdata
);
  import bstc_pkg::*;

  trim_t       trim_r;
  logic        f_valid, f_ready, d_valid, d_ready;
  logic [63:0] f_num, d_quot;
  logic [30:0] f_den;
  side_t       f_side, d_side;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trim_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TEMP_TRIM:  trim_r.temp_trim       <= cfg_wdata[47:0];
        CFG_PRESS_LOW:  trim_r.press_trim_low  <= cfg_wdata;
        CFG_PRESS_MID:  trim_r.press_trim_mid  <= cfg_wdata;
        CFG_PRESS_HIGH: trim_r.press_trim_high <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  bstc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_data  (in_data),
    .trim     (trim_r),
    .dn_valid (f_valid),
    .dn_ready (f_ready),
    .dn_num   (f_num),
    .dn_den   (f_den),
    .dn_side  (f_side)
  );

  bstc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (f_valid),
    .up_ready (f_ready),
    .up_num   (f_num),
    .up_den   (f_den),
    .up_side  (f_side),
    .dn_valid (d_valid),
    .dn_ready (d_ready),
    .dn_quot  (d_quot),
    .dn_side  (d_side)
  );

  bstc_post u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (d_valid),
    .up_ready (d_ready),
    .up_quot  (d_quot),
    .up_side  (d_side),
    .trim     (trim_r),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (out_data)
  );

endmodule

// ===== sim/baro_sensor_trim_compensation_unit_tb.sv =====
// testbench for baro_sensor_trim_compensation_unit: directed table then random requests,
// each result checked against its table value or an in-bench integer compensation predictor
// depends on bstc_pkg and the unit rtl
`timescale 1ns / 100ps

module baro_sensor_trim_compensation_unit_tb;
  import bstc_pkg::*;

  typedef struct packed {
    logic [19:0] raw_t;
    logic [19:0] raw_p;
    logic        typed;
    out_item_t   exp;
  } stim_row_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;
  logic       cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;

  logic [63:0] trim_tw, trim_pl, trim_pm, trim_ph;
  out_item_t   comp_expected_q[$];
  stim_row_t   dir_rows[20];
  logic        cur_typed;
  out_item_t   cur_exp;
  int unsigned accepted_cnt, result_cnt, err_cnt, invalid_cnt, cycle_cnt;
  int unsigned hold_off;
  bit          idle_on;

  baro_sensor_trim_compensation_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [63:0] sdiv_trunc(logic signed [63:0] n,
                                                     logic signed [63:0] dv);
    logic [63:0] un, ud, q;
    un = n[63] ? -n : n;
    ud = dv[63] ? -dv : dv;
    q = un / ud;
    return (n[63] ^ dv[63]) ? -q : q;
  endfunction

  function automatic out_item_t compensate(logic [19:0] rt, logic [19:0] rp);
    logic signed [63:0] adt, adp, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic signed [63:0] d1, v1, d2, v2, fine, tc, a, b, p, ps, c, d;
    out_item_t r;
    adt = {44'd0, rt};
    adp = {44'd0, rp};
    t1 = {48'd0, trim_tw[15:0]};
    t2 = {{48{trim_tw[31]}}, trim_tw[31:16]};
    t3 = {{48{trim_tw[47]}}, trim_tw[47:32]};
    p1 = {48'd0, trim_pl[15:0]};
    p2 = {{48{trim_pl[31]}}, trim_pl[31:16]};
    p3 = {{48{trim_pl[47]}}, trim_pl[47:32]};
    p4 = {{48{trim_pl[63]}}, trim_pl[63:48]};
    p5 = {{48{trim_pm[15]}}, trim_pm[15:0]};
    p6 = {{48{trim_pm[31]}}, trim_pm[31:16]};
    p7 = {{48{trim_pm[47]}}, trim_pm[47:32]};
    p8 = {{48{trim_pm[63]}}, trim_pm[63:48]};
    p9 = {{48{trim_ph[15]}}, trim_ph[15:0]};
    d1 = (adt >>> 3) - (t1 <<< 1);
    v1 = (d1 * t2) >>> 11;
    d2 = (adt >>> 4) - t1;
    v2 = (((d2 * d2) >>> 12) * t3) >>> 14;
    fine = v1 + v2;
    tc = (fine * 64'sd5 + 64'sd128) >>> 8;
    a = fine - 64'sd128000;
    b = a * a * p6;
    b = b + ((a * p5) <<< 17);
    b = b + (p4 <<< 35);
    a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
    a = (((64'sd1 <<< 47) + a) * p1) >>> 33;
    r.temperature_centi = tc[31:0];
    r.fine_temperature  = fine[31:0];
    r.pressure_q24_8    = '0;
    r.pressure_valid    = 1'b0;
    if (a != 0) begin
      p = 64'sd1048576 - adp;
      p = sdiv_trunc(((p <<< 31) - b) * 64'sd3125, a);
      ps = p >>> 13;
      c = (p9 * ps * ps) >>> 25;
      d = (p8 * p) >>> 19;
      p = ((p + c + d) >>> 8) + (p7 <<< 4);
      r.pressure_q24_8 = p[31:0];
      r.pressure_valid = 1'b1;
    end
    return r;
  endfunction

  // request and result monitor
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n) begin
      cycle_cnt++;
      if (cycle_cnt > 400000) begin
        $display("%0t: timeout, %0d results outstanding", $time, comp_expected_q.size());
        $display("baro_sensor_trim_compensation_unit test failed");
        $finish;
      end
      if (in_valid && in_ready) begin
        accepted_cnt++;
        comp_expected_q.push_back(cur_typed ? cur_exp
                                            : compensate(in_data.raw_temperature,
                                                         in_data.raw_pressure));
      end
      if (out_valid && out_ready) begin
        result_cnt++;
        if (!out_data.pressure_valid) invalid_cnt++;
        if (comp_expected_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result %h", $time, out_data);
        end else begin
          e = comp_expected_q.pop_front();
          if (e.temperature_centi !== out_data.temperature_centi) begin
            err_cnt++;
            $display("%0t: temperature_centi exp %0d got %0d", $time,
                     e.temperature_centi, out_data.temperature_centi);
          end
          if (e.fine_temperature !== out_data.fine_temperature) begin
            err_cnt++;
            $display("%0t: fine_temperature exp %0d got %0d", $time,
                     e.fine_temperature, out_data.fine_temperature);
          end
          if (e.pressure_q24_8 !== out_data.pressure_q24_8) begin
            err_cnt++;
            $display("%0t: pressure_q24_8 exp %h got %h", $time,
                     e.pressure_q24_8, out_data.pressure_q24_8);
          end
          if (e.pressure_valid !== out_data.pressure_valid) begin
            err_cnt++;
            $display("%0t: pressure_valid exp %b got %b", $time,
                     e.pressure_valid, out_data.pressure_valid);
          end
        end
      end
    end
  end

  // receiver: random stall bursts plus one long hold-off on request
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        hold_off--;
        out_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send(logic [19:0] rt, logic [19:0] rp, logic typed, out_item_t exp);
    int unsigned n;
    n = accepted_cnt;
    cur_typed = typed;
    cur_exp = exp;
    in_data <= '{raw_temperature: rt, raw_pressure: rp};
    in_valid <= 1'b1;
    do @(negedge clk); while (accepted_cnt == n);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (comp_expected_q.size() != 0) @(negedge clk);
    repeat (90) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      CFG_TEMP_TRIM:  trim_tw = v & 64'h0000_FFFF_FFFF_FFFF;
      CFG_PRESS_LOW:  trim_pl = v;
      CFG_PRESS_MID:  trim_pm = v;
      CFG_PRESS_HIGH: trim_ph = v & 64'hFFFF;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_word(int mode, logic [15:0] nominal);
    logic [15:0] ext[4];
    ext = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF};
    case (mode)
      0: return nominal + 16'($signed($urandom_range(0, 200)) - 100);
      1: return 16'($urandom);
      default: return ext[$urandom_range(0, 3)];
    endcase
  endfunction

  // mode 0 near-nominal, 1 fully random, 2 extreme words; upper junk checks masking
  task automatic load_trims(int mode);
    write_reg(CFG_TEMP_TRIM, {16'($urandom), pick_word(mode, 16'hFC18),
                              pick_word(mode, 16'd26435), pick_word(mode, 16'd27504)});
    write_reg(CFG_PRESS_LOW, {pick_word(mode, 16'd2855), pick_word(mode, 16'd3024),
                              pick_word(mode, 16'hD643), pick_word(mode, 16'd36477)});
    write_reg(CFG_PRESS_MID, {pick_word(mode, 16'hC6F8), pick_word(mode, 16'd15500),
                              pick_word(mode, 16'hFFF9), pick_word(mode, 16'd140)});
    write_reg(CFG_PRESS_HIGH, {48'($urandom), pick_word(mode, 16'd6000)});
  endtask

  function automatic logic [19:0] rand_raw(logic [19:0] nominal);
    case ($urandom_range(0, 9))
      0: return 20'h00000;
      1: return 20'hFFFFF;
      2, 3: return 20'($urandom);
      default: return nominal + 20'($urandom_range(0, 80000)) - 20'd40000;
    endcase
  endfunction

  initial begin
    out_item_t zero_res;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    trim_tw = '0;
    trim_pl = '0;
    trim_pm = '0;
    trim_ph = '0;
    cur_typed = 1'b0;
    cur_exp = '0;
    accepted_cnt = 0;
    result_cnt = 0;
    err_cnt = 0;
    invalid_cnt = 0;
    cycle_cnt = 0;
    hold_off = 0;
    idle_on = 1'b1;
    zero_res = '0;

    // zero trims: zero fine temperature and a zero divisor
    dir_rows[0]  = '{20'h00000, 20'h00000, 1'b1, zero_res};
    dir_rows[1]  = '{20'hFFFFF, 20'hFFFFF, 1'b1, zero_res};
    dir_rows[2]  = '{20'h00000, 20'hFFFFF, 1'b1, zero_res};
    dir_rows[3]  = '{20'hFFFFF, 20'h00000, 1'b1, zero_res};
    dir_rows[4]  = '{20'hAAAAA, 20'h55555, 1'b1, zero_res};
    dir_rows[5]  = '{20'h55555, 20'hAAAAA, 1'b1, zero_res};
    // nominal trims
    dir_rows[6]  = '{20'd519888, 20'd415148, 1'b0, zero_res};
    dir_rows[7]  = '{20'h00000, 20'h00000, 1'b0, zero_res};
    dir_rows[8]  = '{20'hFFFFF, 20'hFFFFF, 1'b0, zero_res};
    dir_rows[9]  = '{20'h00000, 20'hFFFFF, 1'b0, zero_res};
    dir_rows[10] = '{20'hFFFFF, 20'h00000, 1'b0, zero_res};
    dir_rows[11] = '{20'h80000, 20'h80000, 1'b0, zero_res};
    dir_rows[12] = '{20'hAAAAA, 20'h55555, 1'b0, zero_res};
    dir_rows[13] = '{20'h55555, 20'hAAAAA, 1'b0, zero_res};
    dir_rows[14] = '{20'd440000, 20'd300000, 1'b0, zero_res};
    dir_rows[15] = '{20'd600000, 20'd500000, 1'b0, zero_res};
    // extreme trim words
    dir_rows[16] = '{20'h00000, 20'h00000, 1'b0, zero_res};
    dir_rows[17] = '{20'hFFFFF, 20'hFFFFF, 1'b0, zero_res};
    dir_rows[18] = '{20'h7FFFF, 20'h00001, 1'b0, zero_res};
    dir_rows[19] = '{20'h00001, 20'h7FFFF, 1'b0, zero_res};

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      if (i == 6) begin
        drain();
        write_reg(CFG_TEMP_TRIM, 64'hFFFF_FC18_6743_6B70);
        write_reg(CFG_PRESS_LOW, 64'h0B27_0BD0_D643_8E7D);
        write_reg(CFG_PRESS_MID, 64'hC6F8_3C8C_FFF9_008C);
        write_reg(CFG_PRESS_HIGH, 64'h1770);
      end else if (i == 16) begin
        drain();
        write_reg(CFG_TEMP_TRIM, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_PRESS_LOW, 64'h8000_8000_8000_FFFF);
        write_reg(CFG_PRESS_MID, 64'h7FFF_7FFF_7FFF_7FFF);
        write_reg(CFG_PRESS_HIGH, 64'h8000);
      end
      send(dir_rows[i].raw_t, dir_rows[i].raw_p, dir_rows[i].typed, dir_rows[i].exp);
    end

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      load_trims(ph == 1 ? 1 : (ph == 3 ? 2 : 0));
      if (ph == 5) idle_on = 1'b0;
      for (int k = 0; k < 90; k++) begin
        if (ph == 2 && k == 10) hold_off = 300;
        if (ph == 4 && k == 45) begin
          in_valid <= 1'b0;
          @(negedge clk);
          while (comp_expected_q.size() != 0) @(negedge clk);
        end
        send(rand_raw(20'd519888), rand_raw(20'd415148), 1'b0, zero_res);
      end
    end

    drain();
    $display("covered %0d requests over zero, nominal, random and extreme trim sets",
             accepted_cnt);
    $display("%0d results checked, %0d with a zero divisor, %0d mismatches",
             result_cnt, invalid_cnt, err_cnt);
    if (err_cnt == 0 && comp_expected_q.size() == 0) begin
      $display("baro_sensor_trim_compensation_unit test passed");
    end else begin
      $display("baro_sensor_trim_compensation_unit test failed");
    end
    $finish;
  end

endmodule
